### src/lbfdb_pkg.sv
`timescale 1ns / 1ps

package lbfdb_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int PORT_BITS     = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    // The ingress port field is eight bits wide, so no more than that is kept.
    localparam int PORT_W        = (PORT_BITS < 8) ? PORT_BITS : 8;
    localparam int MAC_W         = 48;
    localparam int TIME_W        = 32;
    localparam int TIMEOUT_W     = 16;
    localparam logic [TIMEOUT_W-1:0] DEFAULT_AGE_TIMEOUT = 16'd300;

    localparam logic [1:0] ACT_DROP    = 2'd0;
    localparam logic [1:0] ACT_FORWARD = 2'd1;
    localparam logic [1:0] ACT_FLOOD   = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] tstamp;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LEARN,
        ST_AGE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic cnt_clr;
        logic cnt_inc;
        logic clear_wr;
        logic load_item;
        logic scan;
        logic learn;
        logic delete;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_done;
        logic stale;
        logic out_free;
    } sts_t;

endpackage

### src/lbfdb_ctrl.sv
`timescale 1ns / 1ps

module lbfdb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    input  logic            item_short,
    output logic            s_tready,
    input  lbfdb_pkg::sts_t sts,
    output lbfdb_pkg::cmd_t cmd
);
    import lbfdb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.cnt_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = item_short ? ST_OUT : ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.cnt_done) state_next = ST_LEARN;
            end
            ST_LEARN: state_next = ST_AGE;
            ST_AGE:   state_next = ST_OUT;
            ST_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = !sts.cnt_done;
                cmd.cnt_inc  = !sts.cnt_done;
            end
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.cnt_clr   = 1'b1;
                cmd.load_item = s_tvalid;
            end
            ST_SCAN: begin
                cmd.scan    = 1'b1;
                cmd.cnt_inc = !sts.cnt_done;
            end
            ST_LEARN: cmd.learn  = 1'b1;
            ST_AGE:   cmd.delete = sts.stale;
            ST_OUT:   cmd.out_load = sts.out_free;
            default:  cmd = '0;
        endcase
    end

endmodule

### src/lbfdb_dp.sv
`timescale 1ns / 1ps

module lbfdb_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lbfdb_pkg::TIMEOUT_W-1:0]   cfg_wr_data,
    input  logic [135:0]                      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,
    output logic [1:0]                        m_tuser,
    input  lbfdb_pkg::cmd_t                   cmd,
    output lbfdb_pkg::sts_t                   sts
);
    import lbfdb_pkg::*;

    entry_t table_mem [TABLE_ENTRIES];

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 cnt_done;
    logic [IDX_W-1:0]     addr;

    logic [MAC_W-1:0]  src_reg;
    logic [MAC_W-1:0]  dst_reg;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] now_reg;

    entry_t           rd_data_reg;
    logic             eval_en_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    logic              src_hit_reg;
    logic [IDX_W-1:0]  src_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              dst_hit_reg;
    logic [IDX_W-1:0]  dst_idx_reg;
    logic [PORT_W-1:0] dst_port_reg;
    logic [TIME_W-1:0] dst_time_reg;

    logic [1:0]        res_action_reg;
    logic [PORT_W-1:0] res_port_reg;
    logic              res_failed_reg;
    logic              stale_reg;

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [1:0]        out_action_reg;
    logic [7:0]        out_port_reg;
    logic              out_failed_reg;

    logic              learned;
    logic [IDX_W-1:0]  learn_idx;
    logic              same_mac;
    logic [TIME_W-1:0] age;
    logic              aged_out;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    assign cnt_done = (cnt_reg == CNT_W'(TABLE_ENTRIES));
    assign addr     = cnt_reg[IDX_W-1:0];

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clr) begin
            cnt_next = '0;
        end else if (cmd.cnt_inc) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            eval_en_reg  <= 1'b0;
            timeout_reg  <= DEFAULT_AGE_TIMEOUT;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            eval_en_reg  <= cmd.scan && !cnt_done;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) timeout_reg <= cfg_wr_data;
        end
    end

    // Table read, one entry per cycle during the scan.
    always_ff @(posedge aclk) begin
        if (cmd.scan && !cnt_done) begin
            rd_data_reg  <= table_mem[addr];
            eval_idx_reg <= addr;
        end
    end

    assign learned   = src_hit_reg || free_found_reg;
    assign learn_idx = src_hit_reg ? src_idx_reg : free_idx_reg;
    assign same_mac  = (src_reg == dst_reg);
    assign age       = now_reg - dst_time_reg;
    assign aged_out  = (age > TIME_W'(timeout_reg));

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr;
        wr_data = '0;
        if (cmd.clear_wr) begin
            wr_en = 1'b1;
        end else if (cmd.learn) begin
            wr_en          = learned;
            wr_addr        = learn_idx;
            wr_data.valid  = 1'b1;
            wr_data.mac    = src_reg;
            wr_data.port   = port_reg;
            wr_data.tstamp = now_reg;
        end else if (cmd.delete) begin
            wr_en   = 1'b1;
            wr_addr = dst_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) table_mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            src_reg        <= s_tdata[47:0];
            dst_reg        <= s_tdata[95:48];
            port_reg       <= s_tdata[96 +: PORT_W];
            now_reg        <= s_tdata[135:104];
            src_hit_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            dst_hit_reg    <= 1'b0;
            res_action_reg <= ACT_DROP;
            res_port_reg   <= '0;
            res_failed_reg <= 1'b0;
            stale_reg      <= 1'b0;
        end else if (eval_en_reg) begin
            if (rd_data_reg.valid && rd_data_reg.mac == src_reg) begin
                src_hit_reg <= 1'b1;
                src_idx_reg <= eval_idx_reg;
            end
            if (!rd_data_reg.valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= eval_idx_reg;
            end
            if (rd_data_reg.valid && rd_data_reg.mac == dst_reg) begin
                dst_hit_reg  <= 1'b1;
                dst_idx_reg  <= eval_idx_reg;
                dst_port_reg <= rd_data_reg.port;
                dst_time_reg <= rd_data_reg.tstamp;
            end
        end else if (cmd.learn) begin
            res_failed_reg <= !learned;
            res_port_reg   <= '0;
            stale_reg      <= 1'b0;
            // The destination equal to the source sees the entry just written.
            if (same_mac) begin
                res_action_reg <= learned ? ACT_DROP : ACT_FLOOD;
            end else if (!dst_hit_reg) begin
                res_action_reg <= ACT_FLOOD;
            end else if (aged_out) begin
                res_action_reg <= ACT_FLOOD;
                stale_reg      <= 1'b1;
            end else if (dst_port_reg == port_reg) begin
                res_action_reg <= ACT_DROP;
            end else begin
                res_action_reg <= ACT_FORWARD;
                res_port_reg   <= dst_port_reg;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_action_reg <= res_action_reg;
            out_port_reg   <= 8'(res_port_reg);
            out_failed_reg <= res_failed_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {7'd0, out_failed_reg, out_port_reg};

    assign sts.cnt_done = cnt_done;
    assign sts.stale    = stale_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

### src/l2_learning_bridge_fdb.sv
`timescale 1ns / 1ps
// Each full frame header is handled by a linear scan that reads one table entry per cycle
// through the single memory read port; a short frame skips the scan. A new header is
// accepted only once the previous result has been loaded into the output register.
// Reset (aresetn low, synchronous) restores the timeout to 300 s and starts a clearing
// pass over all TABLE_ENTRIES entries, during which no beat is accepted.

module l2_learning_bridge_fdb (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: ageing timeout in seconds.
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data,
    // Input channel.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,  // src_mac[47:0], dst_mac[95:48], in_port[103:96],
                                   // now_sec[135:104]
    input  logic         s_tuser,  // frame_short
    // Result channel.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,  // out_port[7:0], learn_failed[8], zeros above
    output logic [1:0]   m_tuser   // action
);
    import lbfdb_pkg::*;

    // The controller sequences each beat not flagged short through a scan of the whole table,
    // which finds the source entry, the lowest free slot and the destination
    // entry in one pass. Learning is one write, an aged destination is deleted
    // with a second write, and the result then waits in the output register; a short beat skips all this.
    cmd_t cmd;
    sts_t sts;

    lbfdb_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .item_short (s_tuser),
        .s_tready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    lbfdb_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
